### rtl/irm_pkg.sv
// Package for the incremental reachability matrix.
// Holds the node count, field widths and the sequencer state type.
// No dependencies; every other file in rtl/ imports it.
package irm_pkg;

    // Number of nodes; each row of the matrix has one bit per node.
    localparam int NODE_COUNT = 64;

    // Field widths fixed by the transaction format.
    localparam int NODE_W = 6;
    localparam int ACT_W  = 1;

    // Row address width follows the node count.
    localparam int ADDR_W = $clog2(NODE_COUNT);

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_ADD   = 1'b0;
    localparam logic [ACT_W-1:0] ACT_QUERY = 1'b1;

    typedef logic [NODE_W-1:0]     t_node;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [NODE_COUNT-1:0] t_row;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_QRY  = 5'b00010,
        S_CHK  = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

### rtl/irm_in_if.sv
// Input channel of the reachability matrix: valid/ready plus one request.
// Depends on irm_pkg for the field widths.
interface irm_in_if;
    import irm_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    t_node            src_node;
    t_node            dst_node;

    modport source (output valid, output action, output src_node, output dst_node,
                    input ready);
    modport sink   (input valid, input action, input src_node, input dst_node,
                    output ready);
endinterface

### rtl/irm_out_if.sv
// Output channel of the reachability matrix: valid/ready plus one result.
// Depends on irm_pkg by convention; the payload is two single bits.
interface irm_out_if;
    import irm_pkg::*;

    logic valid;
    logic ready;
    logic answer;
    logic invalid;

    modport source (output valid, output answer, output invalid, input ready);
    modport sink   (input valid, input answer, input invalid, output ready);
endinterface

### rtl/incremental_reachability_matrix.sv
// Top level of the incremental reachability matrix (transitive closure bit matrix).
// Depends on irm_pkg and on the interfaces irm_in_if and irm_out_if.
//
//   channel | dir | payload                      | handshake
//   i_in    | in  | action, src_node, dst_node   | valid/ready
//   o_out   | out | answer, invalid              | valid/ready
//
// A query passes from the accepting idle state through S_QRY and S_DONE to the output
// register. An accepted add edge reads the destination row, checks it in S_CHK and, if
// no cycle is found, walks rows 0 to NODE_COUNT-1 in S_WALK through the matrix memory
// (one read port, one write port), one row read per cycle and written back when it
// reaches the source. A rejected add edge goes from S_CHK to S_DONE, and an invalid
// one goes straight from the idle state to S_DONE.
// Reset is synchronous and active low; it clears one valid flag per row, so the
// matrix reads as all zeros at once without a clearing pass.
// A new transaction is accepted while a finished result still waits in the output
// register; a result that finds the output register occupied waits in S_DONE.
module incremental_reachability_matrix (
    input  logic i_clk,
    input  logic i_rst_n,
    irm_in_if.sink    i_in,
    irm_out_if.source o_out
);
    import irm_pkg::*;

    // Sequencer and request registers.
    t_state      r_state, n_state;
    t_addr       r_src, r_dst;
    logic        r_inrange;
    t_addr       r_k;
    t_row        r_gain;
    logic        r_ans;
    logic        r_inv;

    // Output register.
    logic        r_ovld;
    logic        r_oans;
    logic        r_oinv;

    // Matrix memory, per-row valid flags and the registered read port.
    t_row        mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] r_row_vld;
    t_row        r_rdata;
    logic        r_rd_vld;

    logic        rd_en;
    t_addr       rd_addr;
    logic        wr_en;
    t_row        row_eff;
    logic        acc;
    logic        src_ok;
    logic        dst_ok;
    logic        walk_hit;
    logic        out_free;

    // Range checks on the incoming node indexes.
    assign src_ok = {1'b0, i_in.src_node} < (NODE_W + 1)'(NODE_COUNT);
    assign dst_ok = {1'b0, i_in.dst_node} < (NODE_W + 1)'(NODE_COUNT);

    assign acc      = i_in.valid && i_in.ready;
    assign out_free = !r_ovld || o_out.ready;

    // A row never written reads as all zeros.
    assign row_eff  = r_rd_vld ? r_rdata : '0;
    assign walk_hit = (r_k == r_src) || row_eff[r_src];
    assign wr_en    = (r_state == S_WALK) && walk_hit;

    assign i_in.ready = (r_state == S_IDLE);

    // Read requests: the origin row for a query, the destination row for an add,
    // then rows 0 to NODE_COUNT-1 in turn, row 0 from S_CHK and the rest during the walk.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_k;
        case (r_state)
            S_IDLE: begin
                rd_en   = acc;
                rd_addr = (i_in.action == ACT_QUERY) ? i_in.src_node[ADDR_W-1:0]
                                                     : i_in.dst_node[ADDR_W-1:0];
            end
            S_CHK: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_WALK: begin
                rd_en   = (r_k != ADDR_W'(NODE_COUNT - 1));
                rd_addr = r_k + ADDR_W'(1);
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_k;
            end
        endcase
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_in.action == ACT_QUERY) begin
                        n_state = S_QRY;
                    end else if (!src_ok || !dst_ok || i_in.src_node == i_in.dst_node) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_QRY: begin
                n_state = S_DONE;
            end
            S_CHK: begin
                n_state = row_eff[r_src] ? S_DONE : S_WALK;
            end
            S_WALK: begin
                if (r_k == ADDR_W'(NODE_COUNT - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovld    <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_row_vld[r_k] <= 1'b1;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Request, walk and result registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    r_src     <= i_in.src_node[ADDR_W-1:0];
                    r_dst     <= i_in.dst_node[ADDR_W-1:0];
                    r_inrange <= src_ok && dst_ok;
                    r_ans     <= 1'b0;
                    r_inv     <= (i_in.action == ACT_ADD) &&
                                 (!src_ok || !dst_ok || i_in.src_node == i_in.dst_node);
                end
            end
            S_QRY: begin
                r_ans <= r_inrange && row_eff[r_dst];
            end
            S_CHK: begin
                // The destination already reaching the source means a cycle.
                r_ans  <= row_eff[r_src];
                r_gain <= row_eff | (t_row'(1) << r_dst);
                r_k    <= '0;
            end
            S_WALK: begin
                r_k <= r_k + ADDR_W'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    r_oans <= r_ans;
                    r_oinv <= r_inv;
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // Matrix memory: one write and one read per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_k] <= row_eff | r_gain;
        end
        if (rd_en) begin
            r_rdata  <= mem[rd_addr];
            r_rd_vld <= r_row_vld[rd_addr];
        end
    end

    assign o_out.valid   = r_ovld;
    assign o_out.answer  = r_oans;
    assign o_out.invalid = r_oinv;

    // A new result reaches the output register only from the completion state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_state == S_DONE))
        else $error("output valid rose outside the completion state");

    // The walk always starts at row zero.
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && n_state == S_WALK) |=> (r_k == '0))
        else $error("row walk did not start at row zero");

    // The added reach set never contains the source, so the walk set is stable.
    a_gain_no_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !r_gain[r_src])
        else $error("reach set added during the walk holds the source node");

    // Each walk cycle writes at most the row that its read returned.
    a_walk_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_WALK && $past(rd_en)))
        else $error("matrix write without a preceding row read");

endmodule
